// ===== rtl/audio_master_gain_soft_clip_core_macros.svh =====
// assertion macros for the master gain and soft clip core
// used by the top level only, needs clk_i and rst_ni in scope
`ifndef AUDIO_MASTER_GAIN_SOFT_CLIP_CORE_MACROS_SVH
`define AUDIO_MASTER_GAIN_SOFT_CLIP_CORE_MACROS_SVH

// same-cycle implication, checked outside reset
`define AMGSC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define AMGSC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/amgsc_pkg.sv =====
// shared types, constants and helpers of the master gain and soft clip core
// no dependencies
package amgsc_pkg;

  localparam int unsigned SW    = 24;  // input sample width
  localparam int unsigned OW    = 22;  // output sample width
  localparam int unsigned GW    = 17;  // gain / register width
  localparam int unsigned AW    = 24;  // scaled magnitude width
  localparam int unsigned KW    = 24;  // coefficient width, Q20
  localparam int unsigned DW    = 50;  // numerator / denominator width, Q40
  localparam int unsigned QW    = 22;  // quotient bits, one extra for rounding
  localparam int unsigned NSTEP = 22;  // divider stages, one quotient bit each

  localparam logic [GW-1:0] ONE_Q16  = 17'd65536;
  localparam logic [AW-1:0] ONE_Q20  = 24'd1048576;
  localparam logic [20:0]   KMAX_Q16 = 21'd655360;

  // configuration register indexes
  localparam logic [2:0] CFG_MASTER_VOL = 3'd0;
  localparam logic [2:0] CFG_SOFT_EN    = 3'd1;
  localparam logic [2:0] CFG_SOFTNESS   = 3'd2;
  localparam logic [2:0] CFG_GAIN0      = 3'd3;
  localparam logic [2:0] CFG_GAIN1      = 3'd4;
  localparam logic [2:0] CFG_GAIN2      = 3'd5;
  localparam logic [2:0] CFG_GAIN3      = 3'd6;

  // per-word sideband that travels down the pipeline
  typedef struct packed {
    logic          mode;
    logic          neg;
    logic [AW-1:0] mag;
  } amg_side_t;

  // one divider stage
  typedef struct packed {
    amg_side_t     side;
    logic [DW-1:0] rem;
    logic [DW-1:0] den;
    logic [QW-1:0] quo;
  } amg_div_t;

  // curve coefficient k = 1 + 9*softness, clamped to 10, in Q20
  function automatic logic [KW-1:0] coef_k20(input logic [GW-1:0] softness);
    logic [20:0] k16;
    k16 = 21'(ONE_Q16) + 21'(softness) * 21'd9;
    if (k16 > KMAX_Q16) begin
      k16 = KMAX_Q16;
    end
    return KW'({k16, 4'b0000});
  endfunction

endpackage

// ===== rtl/amgsc_scale.sv =====
// gain stages: magnitude times master volume, times channel gain, round to Q20
// depends on amgsc_pkg
module amgsc_scale import amgsc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  logic                  mode_i,
  input  logic [1:0]            channel_i,
  input  logic signed [SW-1:0]  sample_in_i,
  input  logic [GW-1:0]         master_volume_i,
  input  logic [3:0][GW-1:0]    gain_i,
  output logic                  valid_o,
  output amg_side_t             side_o
);

  logic          v1_q, v2_q, v3_q;
  logic          mode1_q, mode2_q, neg1_q, neg2_q;
  logic [1:0]    ch1_q;
  logic [40:0]   p1_d, p1_q;
  logic [57:0]   p2_d, p2_q, sum3;
  logic [SW-1:0] mag;
  logic [GW-1:0] mv;
  amg_side_t     side3_d, side3_q;

  // magnitude and clamped master volume
  always_comb begin
    mag  = sample_in_i[SW-1] ? SW'(-sample_in_i) : SW'(sample_in_i);
    mv   = (master_volume_i > ONE_Q16) ? ONE_Q16 : master_volume_i;
    p1_d = {17'b0, mag} * {24'b0, mv};
  end

  // channel gain product
  assign p2_d = {17'b0, p1_q} * {41'b0, gain_i[ch1_q]};

  // round half away from zero on the magnitude
  always_comb begin
    sum3          = p2_q + 58'h0_8000_0000;
    side3_d.mode  = mode2_q;
    side3_d.neg   = neg2_q;
    side3_d.mag   = sum3[55:32];
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mode1_q <= mode_i;
      neg1_q  <= sample_in_i[SW-1];
      ch1_q   <= channel_i;
      p1_q    <= p1_d;
      mode2_q <= mode1_q;
      neg2_q  <= neg1_q;
      p2_q    <= p2_d;
      side3_q <= side3_d;
    end
  end

  assign valid_o = v3_q;
  assign side_o  = side3_q;

endmodule

// ===== rtl/amgsc_terms.sv =====
// curve terms: a*a and a*k, then numerator and denominator in Q40
// depends on amgsc_pkg
module amgsc_terms import amgsc_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  amg_side_t     side_i,
  input  logic [KW-1:0] k20_i,
  output logic          valid_o,
  output amg_side_t     side_o,
  output logic [DW-1:0] num_o,
  output logic [DW-1:0] den_o
);

  logic          v4_q, v5_q;
  amg_side_t     side4_q, side5_q;
  logic [47:0]   aa_d, ka_d, aa_q, ka_q;
  logic [DW-1:0] num_d, den_d, num_q, den_q;

  // products
  always_comb begin
    aa_d = {24'b0, side_i.mag} * {24'b0, side_i.mag};
    ka_d = {24'b0, side_i.mag} * {24'b0, k20_i};
  end

  // num = a*a + k*a, den = a*a + (k-1)*a + 1.0
  always_comb begin
    num_d = DW'(aa_q) + DW'(ka_q);
    den_d = num_d - (DW'(side4_q.mag) << 20) + (DW'(1) << 40);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else if (en_i) begin
      v4_q <= valid_i;
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side4_q <= side_i;
      aa_q    <= aa_d;
      ka_q    <= ka_d;
      side5_q <= side4_q;
      num_q   <= num_d;
      den_q   <= den_d;
    end
  end

  assign valid_o = v5_q;
  assign side_o  = side5_q;
  assign num_o   = num_q;
  assign den_o   = den_q;

endmodule

// ===== rtl/amgsc_div.sv =====
// pipelined restoring divider, one quotient bit per stage
// depends on amgsc_pkg
module amgsc_div import amgsc_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  amg_side_t     side_i,
  input  logic [DW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic          valid_o,
  output amg_side_t     side_o,
  output logic [QW-1:0] quo_o
);

  logic     [NSTEP-1:0] vld_q;
  amg_div_t             st_q [NSTEP];

  for (genvar g = 0; g < NSTEP; g++) begin : g_step
    logic [DW:0] src, diff;
    logic        ge;
    amg_div_t    st_d;

    // first stage takes the integer bit, the rest shift the remainder
    always_comb begin
      if (g == 0) begin
        src       = {1'b0, num_i};
        st_d.side = side_i;
        st_d.den  = den_i;
        st_d.quo  = '0;
      end else begin
        src       = {st_q[g-1].rem, 1'b0};
        st_d.side = st_q[g-1].side;
        st_d.den  = st_q[g-1].den;
        st_d.quo  = st_q[g-1].quo;
      end
      diff     = src - {1'b0, st_d.den};
      ge       = (src >= {1'b0, st_d.den});
      st_d.rem = ge ? diff[DW-1:0] : src[DW-1:0];
      st_d.quo = {st_d.quo[QW-2:0], ge};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[g] <= 1'b0;
      end else if (en_i) begin
        vld_q[g] <= (g == 0) ? valid_i : vld_q[(g == 0) ? 0 : g-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_q[g] <= st_d;
      end
    end
  end

  assign valid_o = vld_q[NSTEP-1];
  assign side_o  = st_q[NSTEP-1].side;
  assign quo_o   = st_q[NSTEP-1].quo;

endmodule

// ===== rtl/audio_master_gain_soft_clip_core.sv =====
// path: an accepted word passes the scale, terms, divider and output registers to its result word
// throughput: one word per cycle unless a held output word stalls it; the pipeline moves as a whole, one
// quotient bit of the 22-stage divider per stage sets the depth
// reset: config registers return to their defaults, sticky clip flag clears,
// all valid bits clear; no clearing pass
module audio_master_gain_soft_clip_core import amgsc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 mode_i,
  input  logic [1:0]           channel_i,
  input  logic signed [SW-1:0] sample_in_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic signed [OW-1:0] sample_out_o,
  output logic                 clipped_now_o,
  output logic                 clip_flag_o,
  input  logic                 cfg_we_i,
  input  logic [2:0]           cfg_idx_i,
  input  logic [GW-1:0]        cfg_data_i
);

`include "audio_master_gain_soft_clip_core_macros.svh"

  logic             adv;
  logic [GW-1:0]    master_vol_q, softness_q;
  logic             soft_en_q;
  logic [3:0][GW-1:0] gain_q;
  logic             sc_valid, tm_valid, dv_valid;
  amg_side_t        sc_side, tm_side, dv_side;
  logic [DW-1:0]    num, den;
  logic [QW-1:0]    quo;
  logic [QW:0]      quo_inc;
  logic [AW-1:0]    sel_mag;
  logic [20:0]      y_mag;
  logic             clip;
  logic [OW-1:0]    y;
  logic             out_valid_q, clipped_q, flag_q, sticky_q, sticky_d;
  logic [OW-1:0]    sample_q;

  // whole pipeline advances when the output word is free or being taken
  assign adv        = !out_valid_q || !out_stall_i;
  assign in_stall_o = !adv;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      master_vol_q <= ONE_Q16;
      soft_en_q    <= 1'b0;
      softness_q   <= 17'd32768;
      gain_q       <= {4{ONE_Q16}};
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MASTER_VOL: master_vol_q <= cfg_data_i;
        CFG_SOFT_EN:    soft_en_q    <= cfg_data_i[0];
        CFG_SOFTNESS:   softness_q   <= cfg_data_i;
        CFG_GAIN0:      gain_q[0]    <= cfg_data_i;
        CFG_GAIN1:      gain_q[1]    <= cfg_data_i;
        CFG_GAIN2:      gain_q[2]    <= cfg_data_i;
        CFG_GAIN3:      gain_q[3]    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  amgsc_scale u_scale (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .en_i            (adv),
    .valid_i         (in_valid_i),
    .mode_i          (mode_i),
    .channel_i       (channel_i),
    .sample_in_i     (sample_in_i),
    .master_volume_i (master_vol_q),
    .gain_i          (gain_q),
    .valid_o         (sc_valid),
    .side_o          (sc_side)
  );

  amgsc_terms u_terms (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (sc_valid),
    .side_i  (sc_side),
    .k20_i   (coef_k20(softness_q)),
    .valid_o (tm_valid),
    .side_o  (tm_side),
    .num_o   (num),
    .den_o   (den)
  );

  amgsc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (tm_valid),
    .side_i  (tm_side),
    .num_i   (num),
    .den_i   (den),
    .valid_o (dv_valid),
    .side_o  (dv_side),
    .quo_o   (quo)
  );

  // round the curve, pick linear or curve, hard clip, restore sign
  always_comb begin
    quo_inc = {1'b0, quo} + (QW+1)'(1);
    sel_mag = soft_en_q ? AW'(quo_inc[QW:1]) : dv_side.mag;
    clip    = (sel_mag > ONE_Q20);
    y_mag   = clip ? ONE_Q20[20:0] : sel_mag[20:0];
    y       = dv_side.neg ? -{1'b0, y_mag} : {1'b0, y_mag};
  end

  // sticky clip flag, updated in word order at the output
  always_comb begin
    sticky_d = sticky_q;
    if (adv && dv_valid) begin
      if (dv_side.mode) begin
        sticky_d = 1'b0;
      end else if (clip) begin
        sticky_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      sticky_q    <= 1'b0;
    end else begin
      sticky_q <= sticky_d;
      if (adv) begin
        out_valid_q <= dv_valid;
      end
    end
  end

  // output word
  always_ff @(posedge clk_i) begin
    if (adv && dv_valid) begin
      if (dv_side.mode) begin
        sample_q  <= '0;
        clipped_q <= 1'b0;
        flag_q    <= sticky_q;
      end else begin
        sample_q  <= y;
        clipped_q <= clip;
        flag_q    <= 1'b0;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign sample_out_o  = sample_q;
  assign clipped_now_o = clipped_q;
  assign clip_flag_o   = flag_q;

  `AMGSC_ASSERT_IMP(a_clip_full_scale, out_valid_o && clipped_now_o,
                    sample_out_o == 22'sd1048576 || sample_out_o == -22'sd1048576,
                    "clipped word is not at full scale")
  `AMGSC_ASSERT_IMP(a_flag_word_empty, out_valid_o && clip_flag_o,
                    sample_out_o == 22'sd0 && !clipped_now_o,
                    "flag read word carries sample data")
  `AMGSC_ASSERT_IMP(a_clip_sticky, out_valid_o && out_stall_i && clipped_now_o,
                    sticky_q,
                    "clipped word waiting without sticky flag")

endmodule

// ===== tb/sv/audio_master_gain_soft_clip_checker.sv =====
// watcher for the master gain and soft clip core: mirrors the config port,
// predicts each result word and compares it with the output channel
// depends on amgsc_pkg for widths and register indexes
module audio_master_gain_soft_clip_checker import amgsc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_stall_i,
  input  logic                 mode_i,
  input  logic [1:0]           channel_i,
  input  logic signed [SW-1:0] sample_in_i,
  input  logic                 out_valid_i,
  input  logic                 out_stall_i,
  input  logic signed [OW-1:0] sample_out_i,
  input  logic                 clipped_now_i,
  input  logic                 clip_flag_i,
  input  logic                 cfg_we_i,
  input  logic [2:0]           cfg_idx_i,
  input  logic [GW-1:0]        cfg_data_i,
  output int                   fail_count_o,
  output int                   pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [OW-1:0] sample;
    logic          clipped;
    logic          flag;
  } out_word_t;

  // mirrored configuration and sticky flag
  logic [GW-1:0] master_vol;
  logic          soft_on;
  logic [GW-1:0] softness;
  logic [GW-1:0] ch_gain [4];
  logic          sticky;

  out_word_t expected_words[$];

  assign pending_o = expected_words.size();

  // gain, optional soft curve and hard clip of one sample word, or read and clear of the sticky flag
  function automatic out_word_t shape_sample(logic mode, logic [1:0] ch,
                                            logic [SW-1:0] raw);
    out_word_t     res;
    logic          neg;
    logic [63:0]   mag, mv, prod, a, k16, k20, num, den, y;
    logic [127:0]  quo, rem;
    res = '{sample: '0, clipped: 1'b0, flag: 1'b0};
    if (mode) begin
      res.flag = sticky;
      sticky = 1'b0;
      return res;
    end
    neg = raw[SW-1];
    mag = neg ? (64'h1000000 - {40'b0, raw}) : {40'b0, raw};
    mv = (master_vol > ONE_Q16) ? 64'd65536 : {47'b0, master_vol};
    prod = mag * mv * {47'b0, ch_gain[ch]};
    a = (prod + (64'd1 << 31)) >> 32;
    if (soft_on) begin
      k16 = 64'd65536 + 64'd9 * {47'b0, softness};
      if (k16 > 64'd655360) k16 = 64'd655360;
      k20 = k16 << 4;
      num = a * (a + k20);
      den = a * a + (k20 - 64'd1048576) * a + (64'd1 << 40);
      quo = ({64'b0, num} << 20) / {64'b0, den};
      rem = ({64'b0, num} << 20) % {64'b0, den};
      if ((rem << 1) >= {64'b0, den}) quo = quo + 1;
      a = quo[63:0];
    end
    if (a > 64'd1048576) begin
      a = 64'd1048576;
      res.clipped = 1'b1;
      sticky = 1'b1;
    end
    y = neg ? (64'd0 - a) : a;
    res.sample = y[OW-1:0];
    return res;
  endfunction

  // config mirror, prediction on accepted input, comparison on accepted output
  always @(posedge clk_i or negedge rst_ni) begin
    out_word_t exp_w;
    if (!rst_ni) begin
      master_vol = ONE_Q16;
      soft_on = 1'b0;
      softness = 17'd32768;
      for (int i = 0; i < 4; i++) ch_gain[i] = ONE_Q16;
      sticky = 1'b0;
      expected_words.delete();
      fail_count_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_MASTER_VOL: master_vol = cfg_data_i;
          CFG_SOFT_EN:    soft_on = cfg_data_i[0];
          CFG_SOFTNESS:   softness = cfg_data_i;
          CFG_GAIN0:      ch_gain[0] = cfg_data_i;
          CFG_GAIN1:      ch_gain[1] = cfg_data_i;
          CFG_GAIN2:      ch_gain[2] = cfg_data_i;
          CFG_GAIN3:      ch_gain[3] = cfg_data_i;
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_words.size() == 0) begin
          $error("result word with nothing expected: sample_out %0d", sample_out_i);
          fail_count_o++;
        end else begin
          exp_w = expected_words.pop_front();
          if (sample_out_i !== exp_w.sample) begin
            $error("sample_out: expected %0d, got %0d",
                   $signed(exp_w.sample), sample_out_i);
            fail_count_o++;
          end
          if (clipped_now_i !== exp_w.clipped) begin
            $error("clipped_now: expected %0b, got %0b", exp_w.clipped, clipped_now_i);
            fail_count_o++;
          end
          if (clip_flag_i !== exp_w.flag) begin
            $error("clip_flag: expected %0b, got %0b", exp_w.flag, clip_flag_i);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        expected_words.insert(expected_words.size(),
                              shape_sample(mode_i, channel_i, sample_in_i));
      end
    end
  end

endmodule

// ===== tb/sv/tb_audio_master_gain_soft_clip_core.sv =====
// top of the master gain and soft clip core testbench: clock, reset,
// stimulus and verdict; needs amgsc_pkg, the core and the checker module
module tb_audio_master_gain_soft_clip_core;
  import amgsc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] CFG_UNUSED = 3'd7;
  localparam logic       MODE_SAMPLE = 1'b0;
  localparam logic       MODE_READ   = 1'b1;
  localparam int         CYCLE_LIMIT = 300000;
  localparam int         DRAIN_WAIT  = 40;

  logic                 clk, rst_n;
  logic                 in_valid, in_stall, mode, out_valid, out_stall;
  logic [1:0]           channel;
  logic signed [SW-1:0] sample_in;
  logic signed [OW-1:0] sample_out;
  logic                 clipped_now, clip_flag;
  logic                 cfg_we;
  logic [2:0]           cfg_idx;
  logic [GW-1:0]        cfg_data;
  int                   fail_count, pending, cycles, words_sent;
  bit                   idle_on, hold_req;

  audio_master_gain_soft_clip_core dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .mode_i(mode), .channel_i(channel), .sample_in_i(sample_in),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .sample_out_o(sample_out), .clipped_now_o(clipped_now), .clip_flag_o(clip_flag),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data)
  );

  audio_master_gain_soft_clip_checker checker_i (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_i(in_stall),
    .mode_i(mode), .channel_i(channel), .sample_in_i(sample_in),
    .out_valid_i(out_valid), .out_stall_i(out_stall),
    .sample_out_i(sample_out), .clipped_now_i(clipped_now), .clip_flag_i(clip_flag),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // cycle limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_audio_master_gain_soft_clip_core failed");
      $finish;
    end
  end

  // receiver: random stall bursts and one long hold
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (80) @(negedge clk);
        hold_req = 1'b0;
        out_stall <= 1'b0;
      end else if (idle_on && $urandom_range(0, 6) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 3)) @(negedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // one word on the input channel; entered and left at a falling edge
  task automatic send_word(logic m, logic [1:0] ch, logic [SW-1:0] s);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_valid  <= 1'b1;
    mode      <= m;
    channel   <= ch;
    sample_in <= s;
    do @(posedge clk); while (in_stall);
    words_sent++;
    @(negedge clk);
  endtask

  // wait for every expected word
  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [GW-1:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we   <= 1'b0;
    @(negedge clk);
  endtask

  // random sample, biased toward the region around full scale and toward small values
  function automatic logic [SW-1:0] pick_sample();
    logic [SW-1:0] mag;
    case ($urandom_range(0, 3))
      0:       return SW'($urandom);
      1:       mag = SW'($urandom_range(0, 3145728));
      2:       mag = SW'($urandom_range(1040000, 1060000));
      default: mag = SW'($urandom_range(0, 4096));
    endcase
    return $urandom_range(0, 1) ? -mag : mag;
  endfunction

  function automatic logic [GW-1:0] pick_gain();
    case ($urandom_range(0, 3))
      0:       return GW'($urandom_range(0, 131071));
      1:       return 17'd131071;
      default: return GW'($urandom_range(32768, 98304));
    endcase
  endfunction

  initial begin
    logic [SW-1:0] dir_s [10];
    dir_s = '{24'd0, 24'd1048576, -24'sd1048576, 24'd8388607, 24'h800000,
              24'd1048577, 24'd1, -24'sd1, 24'd524288, 24'hAAAAAA};
    in_valid = 1'b0; mode = MODE_SAMPLE; channel = '0; sample_in = '0;
    cfg_we = 1'b0; cfg_idx = '0; cfg_data = '0;
    idle_on = 1'b1; hold_req = 1'b0; cycles = 0; words_sent = 0;
    rst_n = 1'b0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed: reset settings, extremes, unity edge, read and clear
    foreach (dir_s[i]) send_word(MODE_SAMPLE, 2'(i), dir_s[i]);
    send_word(MODE_READ, 2'd3, 24'hFFFFFF);
    send_word(MODE_READ, 2'd0, 24'd0);
    drain();
    // soft curve with the coefficient at its floor and its clamp
    write_reg(CFG_SOFT_EN, 17'd1);
    write_reg(CFG_SOFTNESS, 17'd0);
    send_word(MODE_SAMPLE, 2'd0, 24'd8388607);
    send_word(MODE_SAMPLE, 2'd1, 24'h800000);
    send_word(MODE_SAMPLE, 2'd2, 24'd1048576);
    drain();
    write_reg(CFG_SOFTNESS, 17'd131071);
    write_reg(CFG_MASTER_VOL, 17'd131071);
    write_reg(CFG_UNUSED, 17'd12345);
    send_word(MODE_SAMPLE, 2'd3, 24'd8388607);
    send_word(MODE_SAMPLE, 2'd0, -24'sd3000000);
    send_word(MODE_SAMPLE, 2'd1, 24'd1000);
    send_word(MODE_READ, 2'd2, 24'd77);
    drain();

    // random phases across settings
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          write_reg(CFG_MASTER_VOL, 17'd0);
          write_reg(CFG_SOFT_EN, 17'd0);
        end
        1: begin
          write_reg(CFG_MASTER_VOL, 17'd65536);
          write_reg(CFG_SOFT_EN, 17'd1);
          write_reg(CFG_SOFTNESS, 17'd65536);
        end
        default: begin
          write_reg(CFG_MASTER_VOL, $urandom_range(0, 2) == 0 ? 17'd131071
                                    : GW'($urandom_range(0, 65536)));
          write_reg(CFG_SOFT_EN, GW'($urandom_range(0, 1)));
          write_reg(CFG_SOFTNESS, GW'($urandom_range(0, 131071)));
        end
      endcase
      write_reg(CFG_GAIN0, ph == 1 ? 17'd131071 : pick_gain());
      write_reg(CFG_GAIN1, ph == 1 ? 17'd0 : pick_gain());
      write_reg(CFG_GAIN2, pick_gain());
      write_reg(CFG_GAIN3, pick_gain());
      idle_on = (ph != 5);
      if (ph == 2) hold_req = 1'b1;
      for (int n = 0; n < 125; n++) begin
        if (ph == 3 && n == 60) drain();
        send_word($urandom_range(0, 9) == 0 ? MODE_READ : MODE_SAMPLE,
                  2'($urandom), pick_sample());
      end
      drain();
    end

    repeat (DRAIN_WAIT) @(negedge clk);
    $display("covered %0d words over directed extremes and six gain/curve settings,",
             words_sent);
    $display("including a long output hold, an input pause and an idle-free stretch");
    if (fail_count == 0) begin
      $display("tb_audio_master_gain_soft_clip_core passed");
    end else begin
      $display("tb_audio_master_gain_soft_clip_core failed");
    end
    $finish;
  end

endmodule
